>>> src/bpra_pkg.sv
// bpra_pkg: shared types and constants for the bitmap page run allocator
// request/response structs, status and opcode codes, controller states
// no dependencies
package bpra_pkg;

	localparam int NUM_PAGES_DEF = 1024;
	localparam int MAP_BYTES_DEF = (NUM_PAGES_DEF + 7) / 8;
	localparam int MAP_AW_DEF    = $clog2(MAP_BYTES_DEF);
	localparam int PAGE_SHIFT    = 12;
	localparam int PAGE_BYTES    = 4096;
	localparam int BYTES_W       = 23;
	localparam int NEED_W        = 12;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_DOUBLE  = 2'd2,
		STAT_RANGE   = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t       opcode;
		logic [22:0]   byte_count;
		logic [9:0]    start_page;
		logic [10:0]   page_count;
	} req_t;

	typedef struct packed {
		status_t       status;
		logic [9:0]    run_start;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_RMW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              hit;
		logic [2:0]        pos;
		logic [NEED_W-1:0] run;
	} scan_res_t;

endpackage

>>> src/bitmap_page_run_allocator.sv
// bitmap_page_run_allocator: first-fit page run allocator over a free-page bitmap
// controller, read-modify-write sequencing and output register
// uses bpra_pkg, bpra_map_mem, bpra_scan
//
// channel  dir  handshake             payload
// req      in   req_valid/req_stall   bpra_pkg::req_t (opcode, byte_count, start_page, page_count)
// rsp      out  rsp_valid/rsp_stall   bpra_pkg::rsp_t (status, run_start)
//
// after reset a clearing pass writes every bitmap byte to all-free, req stalled
// allocate: setup, first-fit byte scan, read-modify-write of the run's bytes; one bitmap read port
// free: setup, read-modify-write of touched bytes; zero-size and rejected requests skip to done
// one request at a time; the next is taken while the previous response waits in rsp
// rsp_stall holds the response register; a new result waits until it is free
module bitmap_page_run_allocator #(
	parameter int NUM_PAGES = bpra_pkg::NUM_PAGES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  bpra_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output bpra_pkg::rsp_t  rsp
);

	localparam int MAP_BYTES = (NUM_PAGES + 7) / 8;
	localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int CW        = AW + 1;
	localparam int PG_LOG    = $clog2(NUM_PAGES);
	localparam int POS_W     = ((PG_LOG > bpra_pkg::NEED_W) ? PG_LOG : bpra_pkg::NEED_W) + 1;
	localparam int NW        = bpra_pkg::NEED_W;
	localparam int SUM_W     = bpra_pkg::BYTES_W + 1;

	bpra_pkg::state_t    state_q, state_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic                vld_s1;
	logic [AW-1:0]       addr_s1;
	logic [NW-1:0]       run_q, run_d;
	logic [NW-1:0]       need_q, need_d;
	logic [POS_W-1:0]    lo_q, lo_d;
	logic [POS_W-1:0]    hi_q, hi_d;
	logic                set_q, set_d;
	logic                rng_q, rng_d;
	logic                dbl_q, dbl_d;
	bpra_pkg::status_t   stat_q, stat_d;
	logic [9:0]          start_q, start_d;
	bpra_pkg::req_t      req_q, req_d;
	logic                rsp_valid_q;
	bpra_pkg::rsp_t      rsp_q;

	logic                issue;
	logic                load_rsp;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [7:0]          wr_data;
	logic [7:0]          rd_data;
	logic [7:0]          byte_mask;
	logic [7:0]          page_ok;
	logic [7:0]          new_byte;
	logic [SUM_W-1:0]    byte_sum;
	logic [NW-1:0]       need_calc;
	logic [POS_W-1:0]    end_x;
	logic                end_over;
	logic [POS_W-1:0]    last_pg;
	logic [POS_W-1:0]    first_pg;
	logic [POS_W-1:0]    hi_byte;
	bpra_pkg::scan_res_t scan;

	bpra_map_mem #(
		.DEPTH (MAP_BYTES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_data (rd_data)
	);

	bpra_scan u_scan (
		.free_bits (rd_data & page_ok),
		.run_in    (run_q),
		.need      (need_q),
		.res       (scan)
	);

	// per-bit page range of the byte just read
	always_comb begin
		logic [POS_W-1:0] pg;
		for (int i = 0; i < 8; i++) begin
			pg = (POS_W'(addr_s1) << 3) | POS_W'(i);
			byte_mask[i] = (pg >= lo_q) && (pg <= hi_q);
			page_ok[i]   = pg < POS_W'(NUM_PAGES);
		end
	end

	assign new_byte  = set_q ? (rd_data | byte_mask) : (rd_data & ~byte_mask);
	assign byte_sum  = SUM_W'(req_q.byte_count) + SUM_W'(bpra_pkg::PAGE_BYTES - 1);
	assign need_calc = byte_sum[bpra_pkg::PAGE_SHIFT +: NW];
	assign end_x     = POS_W'(req_q.start_page) + POS_W'(req_q.page_count);
	assign end_over  = end_x > POS_W'(NUM_PAGES);
	assign last_pg   = (POS_W'(addr_s1) << 3) + POS_W'(scan.pos);
	assign first_pg  = last_pg + POS_W'(1) - POS_W'(need_q);
	assign hi_byte   = hi_q >> 3;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		run_d    = run_q;
		need_d   = need_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		set_d    = set_q;
		rng_d    = rng_q;
		dbl_d    = dbl_q;
		stat_d   = stat_q;
		start_d  = start_q;
		req_d    = req_q;
		issue    = 1'b0;
		load_rsp = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = addr_s1;
		wr_data  = new_byte;
		unique case (state_q)
			bpra_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[AW-1:0];
				wr_data = '1;
				if (cnt_q == CW'(MAP_BYTES - 1)) begin
					cnt_d   = '0;
					state_d = bpra_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			bpra_pkg::ST_IDLE: begin
				if (req_valid) begin
					req_d   = req;
					state_d = bpra_pkg::ST_SETUP;
				end
			end
			bpra_pkg::ST_SETUP: begin
				start_d = '0;
				if (req_q.opcode == bpra_pkg::OP_ALLOC) begin
					need_d = need_calc;
					run_d  = '0;
					cnt_d  = '0;
					if (need_calc == '0) begin
						stat_d  = bpra_pkg::STAT_OK;
						state_d = bpra_pkg::ST_DONE;
					end else if (POS_W'(need_calc) > POS_W'(NUM_PAGES)) begin
						stat_d  = bpra_pkg::STAT_NOSPACE;
						state_d = bpra_pkg::ST_DONE;
					end else begin
						state_d = bpra_pkg::ST_SCAN;
					end
				end else begin
					set_d = 1'b1;
					dbl_d = 1'b0;
					rng_d = end_over;
					if (req_q.page_count == '0) begin
						stat_d  = bpra_pkg::STAT_OK;
						state_d = bpra_pkg::ST_DONE;
					end else if (POS_W'(req_q.start_page) >= POS_W'(NUM_PAGES)) begin
						stat_d  = bpra_pkg::STAT_RANGE;
						state_d = bpra_pkg::ST_DONE;
					end else begin
						lo_d    = POS_W'(req_q.start_page);
						hi_d    = (end_over ? POS_W'(NUM_PAGES) : end_x) - POS_W'(1);
						cnt_d   = CW'(POS_W'(req_q.start_page) >> 3);
						state_d = bpra_pkg::ST_RMW;
					end
				end
			end
			bpra_pkg::ST_SCAN: begin
				if (vld_s1 && scan.hit) begin
					lo_d    = first_pg;
					hi_d    = last_pg;
					set_d   = 1'b0;
					rng_d   = 1'b0;
					dbl_d   = 1'b0;
					start_d = first_pg[9:0];
					cnt_d   = CW'(first_pg >> 3);
					state_d = bpra_pkg::ST_RMW;
				end else if (vld_s1 && addr_s1 == AW'(MAP_BYTES - 1)) begin
					stat_d  = bpra_pkg::STAT_NOSPACE;
					state_d = bpra_pkg::ST_DONE;
				end else begin
					if (vld_s1) begin
						run_d = scan.run;
					end
					if (cnt_q < CW'(MAP_BYTES)) begin
						issue = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			bpra_pkg::ST_RMW: begin
				if (vld_s1) begin
					wr_en = 1'b1;
					dbl_d = dbl_q | (set_q & (|(rd_data & byte_mask)));
				end
				if (vld_s1 && POS_W'(addr_s1) == hi_byte) begin
					if (!set_q) begin
						stat_d = bpra_pkg::STAT_OK;
					end else if (rng_q) begin
						stat_d = bpra_pkg::STAT_RANGE;
					end else if (dbl_d) begin
						stat_d = bpra_pkg::STAT_DOUBLE;
					end else begin
						stat_d = bpra_pkg::STAT_OK;
					end
					state_d = bpra_pkg::ST_DONE;
				end else if (POS_W'(cnt_q) <= hi_byte) begin
					issue = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			bpra_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = bpra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bpra_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpra_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			vld_s1 <= issue;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q[AW-1:0];
		run_q   <= run_d;
		need_q  <= need_d;
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		set_q   <= set_d;
		rng_q   <= rng_d;
		dbl_q   <= dbl_d;
		stat_q  <= stat_d;
		start_q <= start_d;
		req_q   <= req_d;
		if (load_rsp) begin
			rsp_q.status    <= stat_q;
			rsp_q.run_start <= start_q;
		end
	end

	assign req_stall = state_q != bpra_pkg::ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && issue) |-> (wr_addr != cnt_q[AW-1:0]))
		else $error("bitmap read and write hit the same entry");

	a_scan_need_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bpra_pkg::ST_SCAN && vld_s1) |->
		(need_q != '0 && POS_W'(need_q) <= POS_W'(NUM_PAGES)))
		else $error("scan running with an illegal page count");

	a_fail_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != bpra_pkg::STAT_OK) |-> (rsp.run_start == '0))
		else $error("failed request returned a nonzero run start");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |=> rsp_valid)
		else $error("response load lost");
`endif

endmodule

>>> src/bpra_map_mem.sv
// bpra_map_mem: free-page bitmap storage, one byte per entry
// one write port, one read port with registered read data; uses bpra_pkg
module bpra_map_mem #(
	parameter int DEPTH = bpra_pkg::MAP_BYTES_DEF,
	parameter int AW    = bpra_pkg::MAP_AW_DEF
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/bpra_scan.sv
// bpra_scan: first-fit run counter over one bitmap byte
// carries the free-run length across bytes and reports the first bit that completes it
// uses bpra_pkg
module bpra_scan (
	input  logic [7:0]                  free_bits,
	input  logic [bpra_pkg::NEED_W-1:0] run_in,
	input  logic [bpra_pkg::NEED_W-1:0] need,
	output bpra_pkg::scan_res_t         res
);

	always_comb begin
		logic [bpra_pkg::NEED_W-1:0] run;
		logic                        hit;
		logic [2:0]                  pos;
		run = run_in;
		hit = 1'b0;
		pos = '0;
		for (int i = 0; i < 8; i++) begin
			if (!hit) begin
				run = free_bits[i] ? run + 1'b1 : '0;
				if (run == need) begin
					hit = 1'b1;
					pos = 3'(i);
				end
			end
		end
		res.hit = hit;
		res.pos = pos;
		res.run = run;
	end

endmodule

>>> bench/testbench.sv
// testbench for bitmap_page_run_allocator: directed table then random allocate/free traffic
// responses are checked against typed table rows or an in-bench free-page map predictor
// random handshake idling; depends on bpra_pkg and the allocator RTL
`timescale 1ns / 1ps

module testbench;

	localparam int PAGES       = bpra_pkg::NUM_PAGES_DEF;
	localparam int ITEMS       = 1050;
	localparam int CALM_FROM   = 900;
	localparam int HOLD_AT     = 300;
	localparam int DRAIN_AT    = 600;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE      = 300;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		bpra_pkg::req_t  r;
		logic            typed;
		bpra_pkg::rsp_t  want;
	} dir_row_t;

	typedef struct {
		int first;
		int count;
	} page_run_t;

	localparam int DIR_ROWS = 19;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{'{bpra_pkg::OP_ALLOC, 23'd0, 10'd0, 11'd0}, 1'b1, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_ALLOC, 23'd4194304, 10'd0, 11'd0}, 1'b1, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_ALLOC, 23'd1, 10'd0, 11'd0}, 1'b1, '{bpra_pkg::STAT_NOSPACE, 10'd0}},
		'{'{bpra_pkg::OP_ALLOC, 23'h7fffff, 10'd0, 11'd0}, 1'b1, '{bpra_pkg::STAT_NOSPACE, 10'd0}},
		'{'{bpra_pkg::OP_FREE, 23'd0, 10'd0, 11'd1024}, 1'b1, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_FREE, 23'd0, 10'd0, 11'd0}, 1'b1, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_FREE, 23'd0, 10'd5, 11'd1}, 1'b1, '{bpra_pkg::STAT_DOUBLE, 10'd0}},
		'{'{bpra_pkg::OP_FREE, 23'd0, 10'd1023, 11'd2047}, 1'b1, '{bpra_pkg::STAT_RANGE, 10'd0}},
		'{'{bpra_pkg::OP_ALLOC, 23'd4097, 10'd0, 11'd0}, 1'b1, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_ALLOC, 23'd4186112, 10'd0, 11'd0}, 1'b1, '{bpra_pkg::STAT_OK, 10'd2}},
		'{'{bpra_pkg::OP_FREE, 23'd0, 10'd1000, 11'd100}, 1'b1, '{bpra_pkg::STAT_RANGE, 10'd0}},
		'{'{bpra_pkg::OP_ALLOC, 23'd98304, 10'd0, 11'd0}, 1'b1, '{bpra_pkg::STAT_OK, 10'd1000}},
		'{'{bpra_pkg::OP_FREE, 23'd0, 10'd0, 11'd2}, 1'b0, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_ALLOC, 23'd12288, 10'd0, 11'd0}, 1'b0, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_ALLOC, 23'd4096, 10'd0, 11'd0}, 1'b0, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_FREE, 23'd0, 10'd0, 11'd1024}, 1'b0, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_FREE, 23'd0, 10'd1023, 11'd1}, 1'b0, '{bpra_pkg::STAT_OK, 10'd0}},
		'{'{bpra_pkg::OP_FREE, 23'd0, 10'd1023, 11'd2}, 1'b1, '{bpra_pkg::STAT_RANGE, 10'd0}},
		'{'{bpra_pkg::OP_ALLOC, 23'd1, 10'd0, 11'd0}, 1'b0, '{bpra_pkg::STAT_OK, 10'd0}}
	};

	logic            clk = 1'b0;
	logic            arst_n;
	logic            req_valid;
	logic            req_stall;
	bpra_pkg::req_t  req;
	logic            rsp_valid;
	logic            rsp_stall;
	bpra_pkg::rsp_t  rsp;

	logic [PAGES-1:0] page_free;
	bpra_pkg::rsp_t   awaited_rsp [$];
	page_run_t        live_runs [$];
	int               mismatches  = 0;
	int               idle_cycles = 0;
	bit               calm        = 1'b0;
	bit               hold_rsp    = 1'b0;
	bpra_pkg::rsp_t   want_rsp;

	bitmap_page_run_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pages_for(input logic [22:0] bytes);
		return (int'(bytes) + bpra_pkg::PAGE_BYTES - 1) >> bpra_pkg::PAGE_SHIFT;
	endfunction

	// first-fit allocate or release on the predicted free map
	function automatic bpra_pkg::rsp_t allocate_or_release(input bpra_pkg::req_t r);
		bpra_pkg::rsp_t o;
		int   need;
		int   run;
		int   p;
		int   q;
		bit   past_end;
		bit   twice;
		o.status    = bpra_pkg::STAT_OK;
		o.run_start = '0;
		past_end    = 1'b0;
		twice       = 1'b0;
		if (r.opcode == bpra_pkg::OP_ALLOC) begin
			need = pages_for(r.byte_count);
			if (need > PAGES) begin
				o.status = bpra_pkg::STAT_NOSPACE;
			end else if (need > 0) begin
				o.status = bpra_pkg::STAT_NOSPACE;
				run = 0;
				for (p = 0; p < PAGES; p++) begin
					run = page_free[p] ? run + 1 : 0;
					if (run == need) begin
						for (q = p + 1 - need; q <= p; q++) page_free[q] = 1'b0;
						o.status    = bpra_pkg::STAT_OK;
						o.run_start = 10'(p + 1 - need);
						break;
					end
				end
			end
		end else begin
			for (q = 0; q < int'(r.page_count); q++) begin
				p = int'(r.start_page) + q;
				if (p >= PAGES) begin
					past_end = 1'b1;
				end else begin
					if (page_free[p]) twice = 1'b1;
					page_free[p] = 1'b1;
				end
			end
			o.status = past_end ? bpra_pkg::STAT_RANGE :
				(twice ? bpra_pkg::STAT_DOUBLE : bpra_pkg::STAT_OK);
		end
		return o;
	endfunction

	function automatic bpra_pkg::req_t next_request();
		bpra_pkg::req_t r;
		int        k;
		int        idx;
		int        sz;
		page_run_t pr;
		k            = $urandom_range(0, 99);
		r.opcode     = bpra_pkg::OP_ALLOC;
		r.byte_count = 23'($urandom);
		r.start_page = 10'($urandom);
		r.page_count = 11'($urandom);
		if (k < 8) begin
			// raw byte count, roughly half of them oversized
		end else if (k < 16) begin
			r.opcode = bpra_pkg::OP_FREE;
			if (k >= 13) r.page_count = 11'($urandom_range(0, 64));
		end else if (live_runs.size() > 0 && (k < 55 || $countones(page_free) < 256)) begin
			idx          = $urandom_range(0, live_runs.size() - 1);
			pr           = live_runs[idx];
			live_runs.delete(idx);
			r.opcode     = bpra_pkg::OP_FREE;
			r.start_page = 10'(pr.first);
			r.page_count = 11'(pr.count);
		end else begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 16);
			r.byte_count = 23'((sz - 1) * bpra_pkg::PAGE_BYTES +
				$urandom_range(1, bpra_pkg::PAGE_BYTES));
		end
		return r;
	endfunction

	task automatic offer(input bpra_pkg::req_t r, input logic typed,
		input bpra_pkg::rsp_t typed_rsp);
		bpra_pkg::rsp_t pred;
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		pred = allocate_or_release(r);
		awaited_rsp.push_back(typed ? typed_rsp : pred);
		if (r.opcode == bpra_pkg::OP_ALLOC && pred.status == bpra_pkg::STAT_OK &&
			pages_for(r.byte_count) > 0)
			live_runs.push_back('{int'(pred.run_start), pages_for(r.byte_count)});
	endtask

	task automatic sender_gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic flag(input string what, input bpra_pkg::rsp_t want,
		input bpra_pkg::rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected status %0d run_start %0d, got status %0d run_start %0d",
				$realtime, what, want.status, want.run_start, got.status, got.run_start);
	endtask

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		page_free = '1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++) begin
			offer(DIRECTED[i].r, DIRECTED[i].typed, DIRECTED[i].want);
			sender_gap();
		end
		for (int i = 0; i < ITEMS; i++) begin
			if (i == HOLD_AT) hold_rsp = 1'b1;
			if (i == CALM_FROM) calm = 1'b1;
			if (i == DRAIN_AT) begin
				req_valid <= 1'b0;
				while (awaited_rsp.size() != 0) @(posedge clk);
			end
			offer(next_request(), 1'b0, '0);
			sender_gap();
		end
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp.size() == 0) begin
				flag("unexpected response", '0, rsp);
			end else begin
				want_rsp = awaited_rsp.pop_front();
				if (rsp.status !== want_rsp.status || rsp.run_start !== want_rsp.run_start)
					flag("response mismatch", want_rsp, rsp);
			end
		end
	end

	// no-progress watchdog
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

>>> filelist.f
src/bpra_pkg.sv
src/bpra_map_mem.sv
src/bpra_scan.sv
src/bitmap_page_run_allocator.sv
bench/testbench.sv
